// ----- design/rept_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rept_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int ANGLE_WIDTH = 16;
	localparam int TRIG_STAGES = 16;

	localparam int AXIS_WIDTH = 31;
	localparam int EXT_WIDTH  = COORD_WIDTH + 4;
	localparam int TRIG_WIDTH = 34;
	localparam int TRIG_FRAC  = 30;
	localparam int TABLE_LEN  = 24;
	localparam int IDX_W      = $clog2(TABLE_LEN);
	localparam int QUO_WIDTH  = 24;
	localparam int FRAC_BITS  = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int PROD_WIDTH = EXT_WIDTH + TRIG_WIDTH;
	localparam int CMP_WIDTH  = (EXT_WIDTH > AXIS_WIDTH + 8) ? EXT_WIDTH : AXIS_WIDTH + 8;
	localparam int N_STAGES   = 11 + TRIG_STAGES + QUO_WIDTH;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
	localparam logic [AXIS_WIDTH-1:0] AXIS_RESET = AXIS_WIDTH'(65536);

	localparam logic [31:0] ATAN_TURN [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEMI_AXIS_X = 3'd0,
		REG_SEMI_AXIS_Y = 3'd1,
		REG_SEMI_AXIS_Z = 3'd2,
		REG_CENTRE_X    = 3'd3,
		REG_CENTRE_Y    = 3'd4,
		REG_CENTRE_Z    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [EXT_WIDTH-1:0] x;
		logic signed [EXT_WIDTH-1:0] y;
		logic signed [EXT_WIDTH-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [TRIG_WIDTH-1:0] x;
		logic signed [TRIG_WIDTH-1:0] y;
		logic signed [TRIG_WIDTH-1:0] z;
		logic                         flip;
	} cord_t;

	typedef struct packed {
		logic signed [TRIG_WIDTH-1:0] c;
		logic signed [TRIG_WIDTH-1:0] s;
	} trig_t;

	typedef struct packed {
		logic [AXIS_WIDTH-1:0] rem;
		logic [QUO_WIDTH-1:0]  num;
		logic [QUO_WIDTH-1:0]  quo;
		logic                  sat;
	} div_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic                   sat;
	} res_t;

	function automatic logic signed [EXT_WIDTH-1:0] sx(input logic [COORD_WIDTH-1:0] v);
		return {{(EXT_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
	endfunction

	// fold second and third quadrant by half a turn
	function automatic cord_t cord_init(input logic [ANGLE_WIDTH-1:0] ang);
		logic [31:0] a;
		cord_t r;
		a = {ang, {(32-ANGLE_WIDTH){1'b0}}};
		r.flip = a[31] ^ a[30];
		if (r.flip) begin
			a[31] = ~a[31];
		end
		r.x = TRIG_WIDTH'(CORDIC_GAIN);
		r.y = '0;
		r.z = {{(TRIG_WIDTH-32){a[31]}}, a};
		return r;
	endfunction

	// round to nearest, ties away from zero, then apply sign
	function automatic logic signed [EXT_WIDTH+1:0] round_q(input logic [PROD_WIDTH-1:0] p,
			input logic neg);
		logic [PROD_WIDTH-1:0] t;
		logic signed [EXT_WIDTH+1:0] m;
		t = p + {{(PROD_WIDTH-TRIG_FRAC){1'b0}}, 1'b1, {(TRIG_FRAC-1){1'b0}}};
		m = (EXT_WIDTH+2)'(t >> TRIG_FRAC);
		return neg ? -m : m;
	endfunction

endpackage
`default_nettype wire

// ----- design/rept_intf.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rept_query_if;
	import rept_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic signed [COORD_WIDTH-1:0] ship_x;
	logic signed [COORD_WIDTH-1:0] ship_y;
	logic signed [COORD_WIDTH-1:0] ship_z;
	logic [ANGLE_WIDTH-1:0]        angle_x;
	logic [ANGLE_WIDTH-1:0]        angle_y;
	logic [ANGLE_WIDTH-1:0]        angle_z;
	modport source (output valid, point_x, point_y, point_z, ship_x, ship_y, ship_z,
		angle_x, angle_y, angle_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, ship_x, ship_y, ship_z,
		angle_x, angle_y, angle_z, output ready);
endinterface

interface rept_result_if;
	import rept_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] ellipsoid_value;
	logic                   saturated;
	modport source (output valid, ellipsoid_value, saturated, input ready);
	modport sink (input valid, ellipsoid_value, saturated, output ready);
endinterface

interface rept_cfg_if;
	import rept_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/rept_cordic_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rept_cordic_cell (
	input  logic                    clk,
	input  logic                    en,
	input  logic [rept_pkg::IDX_W-1:0] idx,
	input  rept_pkg::cord_t         d,
	output rept_pkg::cord_t         q
);
	import rept_pkg::*;

	logic signed [TRIG_WIDTH-1:0] xs, ys, at;
	cord_t nx;

	always_comb begin
		xs = d.x >>> idx;
		ys = d.y >>> idx;
		at = {{(TRIG_WIDTH-32){1'b0}}, ATAN_TURN[idx]};
		nx.flip = d.flip;
		if (!d.z[TRIG_WIDTH-1]) begin
			nx.x = d.x - ys;
			nx.y = d.y + xs;
			nx.z = d.z - at;
		end else begin
			nx.x = d.x + ys;
			nx.y = d.y - xs;
			nx.z = d.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nx;
		end
	end
endmodule
`default_nettype wire

// ----- design/rept_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rept_div_cell (
	input  logic                             clk,
	input  logic                             en,
	input  logic [rept_pkg::AXIS_WIDTH-1:0]  axis,
	input  rept_pkg::div_t                   d,
	output rept_pkg::div_t                   q
);
	import rept_pkg::*;

	logic [AXIS_WIDTH:0] t, diff;
	logic ge;
	div_t nx;

	always_comb begin
		t = {d.rem, d.num[QUO_WIDTH-1]};
		ge = t >= {1'b0, axis};
		diff = t - {1'b0, axis};
		nx.rem = ge ? diff[AXIS_WIDTH-1:0] : t[AXIS_WIDTH-1:0];
		nx.num = {d.num[QUO_WIDTH-2:0], 1'b0};
		nx.quo = {d.quo[QUO_WIDTH-2:0], ge};
		nx.sat = d.sat;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nx;
		end
	end
endmodule
`default_nettype wire

// ----- design/rept_rot.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rept_rot (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [rept_pkg::EXT_WIDTH-1:0]  u,
	input  logic signed [rept_pkg::EXT_WIDTH-1:0]  w,
	input  logic signed [rept_pkg::EXT_WIDTH-1:0]  p,
	input  rept_pkg::trig_t                     t,
	output logic signed [rept_pkg::EXT_WIDTH-1:0]  u_o,
	output logic signed [rept_pkg::EXT_WIDTH-1:0]  w_o,
	output logic signed [rept_pkg::EXT_WIDTH-1:0]  p_o
);
	import rept_pkg::*;

	logic [EXT_WIDTH-1:0]  ua, wa;
	logic [TRIG_WIDTH-1:0] ca, sa;
	logic [PROD_WIDTH-1:0] cu_s1, sw_s1, su_s1, cw_s1;
	logic ncu_s1, nsw_s1, nsu_s1, ncw_s1;
	logic signed [EXT_WIDTH-1:0] p_s1;
	logic signed [EXT_WIDTH+1:0] u_n, w_n;

	always_comb begin
		ua = u[EXT_WIDTH-1] ? EXT_WIDTH'(-u) : EXT_WIDTH'(u);
		wa = w[EXT_WIDTH-1] ? EXT_WIDTH'(-w) : EXT_WIDTH'(w);
		ca = t.c[TRIG_WIDTH-1] ? TRIG_WIDTH'(-t.c) : TRIG_WIDTH'(t.c);
		sa = t.s[TRIG_WIDTH-1] ? TRIG_WIDTH'(-t.s) : TRIG_WIDTH'(t.s);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cu_s1  <= PROD_WIDTH'(ua) * PROD_WIDTH'(ca);
			sw_s1  <= PROD_WIDTH'(wa) * PROD_WIDTH'(sa);
			su_s1  <= PROD_WIDTH'(ua) * PROD_WIDTH'(sa);
			cw_s1  <= PROD_WIDTH'(wa) * PROD_WIDTH'(ca);
			ncu_s1 <= u[EXT_WIDTH-1] ^ t.c[TRIG_WIDTH-1];
			nsw_s1 <= w[EXT_WIDTH-1] ^ t.s[TRIG_WIDTH-1];
			nsu_s1 <= u[EXT_WIDTH-1] ^ t.s[TRIG_WIDTH-1];
			ncw_s1 <= w[EXT_WIDTH-1] ^ t.c[TRIG_WIDTH-1];
			p_s1   <= p;
		end
	end

	// u' = c*u - s*w, w' = s*u + c*w
	always_comb begin
		u_n = round_q(cu_s1, ncu_s1) - round_q(sw_s1, nsw_s1);
		w_n = round_q(su_s1, nsu_s1) + round_q(cw_s1, ncw_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_o <= u_n[EXT_WIDTH-1:0];
			w_o <= w_n[EXT_WIDTH-1:0];
			p_o <= p_s1;
		end
	end
endmodule
`default_nettype wire

// ----- design/rotated_ellipsoid_point_test_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  modport  payload
// query    sink     point_x/y/z, ship_x/y/z, angle_x/y/z
// result   source   ellipsoid_value, saturated
// cfg      sink     index, data (always ready)
//
// one item per cycle while the skid entry is empty
// most of the pipeline depth comes from the 16 sin/cos cells and the 24 quotient cells
// a two-entry output buffer; query ready drops only while a second result waits in the skid entry
// arst_n clears valid bits and centre registers and sets the semi-axes to 65536; no clearing pass
module rotated_ellipsoid_point_test_core (
	input  logic          clk,
	input  logic          arst_n,
	rept_query_if.sink    query,
	rept_result_if.source result,
	rept_cfg_if.sink      cfg
);
	import rept_pkg::*;

	logic [AXIS_WIDTH-1:0]          semi_axis_q [3];
	logic signed [COORD_WIDTH-1:0]  centre_q [3];
	logic [AXIS_WIDTH-1:0]          axis_eff [3];
	logic [N_STAGES-1:0]            v_q;
	logic                           en, in_xfer;

	vec_t                           diff_s1;
	logic [ANGLE_WIDTH-1:0]         ang_s1 [3];
	cord_t                          cq [3][TRIG_STAGES+1];
	trig_t                          trig_s [3];
	vec_t                           d_dly [TRIG_STAGES+1];
	trig_t                          ty_dly [2];
	trig_t                          tz_dly [4];
	logic signed [EXT_WIDTH-1:0]    rx_u, rx_w, rx_p, ry_u, ry_w, ry_p, rz_u, rz_w, rz_p;
	logic signed [EXT_WIDTH-1:0]    fin [3];
	logic [EXT_WIDTH-1:0]           mag [3];
	div_t                           dq [3][QUO_WIDTH+1];
	logic [2*QUO_WIDTH-1:0]         sq [3];
	logic [VALUE_WIDTH-1:0]         term_s [3];
	logic                           tsat_s [3];
	logic [VALUE_WIDTH+1:0]         total;
	res_t                           res_s, out_q, skid_q;
	logic                           out_v_q, skid_v_q;

	assign cfg.ready = 1'b1;
	assign en        = !skid_v_q;
	assign query.ready = en;
	assign in_xfer   = query.valid && query.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				semi_axis_q[i] <= AXIS_RESET;
				centre_q[i]    <= '0;
			end
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_SEMI_AXIS_X: semi_axis_q[0] <= cfg.data[AXIS_WIDTH-1:0];
				REG_SEMI_AXIS_Y: semi_axis_q[1] <= cfg.data[AXIS_WIDTH-1:0];
				REG_SEMI_AXIS_Z: semi_axis_q[2] <= cfg.data[AXIS_WIDTH-1:0];
				REG_CENTRE_X:    centre_q[0] <= cfg.data[COORD_WIDTH-1:0];
				REG_CENTRE_Y:    centre_q[1] <= cfg.data[COORD_WIDTH-1:0];
				REG_CENTRE_Z:    centre_q[2] <= cfg.data[COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			axis_eff[i] = (semi_axis_q[i] == '0) ? AXIS_WIDTH'(1) : semi_axis_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[N_STAGES-2:0], in_xfer};
		end
	end

	// offset of point from ship and centre
	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1.x <= sx(query.point_x) - sx(query.ship_x) - sx(centre_q[0]);
			diff_s1.y <= sx(query.point_y) - sx(query.ship_y) - sx(centre_q[1]);
			diff_s1.z <= sx(query.point_z) - sx(query.ship_z) - sx(centre_q[2]);
			ang_s1[0] <= query.angle_x;
			ang_s1[1] <= query.angle_y;
			ang_s1[2] <= query.angle_z;
		end
	end

	// sin/cos cells, one lane per angle
	for (genvar l = 0; l < 3; l++) begin : g_trig
		assign cq[l][0] = cord_init(ang_s1[l]);
		for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_cell
			rept_cordic_cell u_cell (
				.clk (clk),
				.en  (en),
				.idx (IDX_W'(k)),
				.d   (cq[l][k]),
				.q   (cq[l][k+1])
			);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				trig_s[l].c <= cq[l][TRIG_STAGES].flip ? -cq[l][TRIG_STAGES].x
					: cq[l][TRIG_STAGES].x;
				trig_s[l].s <= cq[l][TRIG_STAGES].flip ? -cq[l][TRIG_STAGES].y
					: cq[l][TRIG_STAGES].y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_dly[0] <= diff_s1;
			for (int j = 1; j <= TRIG_STAGES; j++) begin
				d_dly[j] <= d_dly[j-1];
			end
			ty_dly[0] <= trig_s[1];
			ty_dly[1] <= ty_dly[0];
			tz_dly[0] <= trig_s[2];
			for (int j = 1; j < 4; j++) begin
				tz_dly[j] <= tz_dly[j-1];
			end
		end
	end

	// about x: u = y, w = z
	rept_rot u_rot_x (
		.clk (clk), .en (en),
		.u (d_dly[TRIG_STAGES].y), .w (d_dly[TRIG_STAGES].z), .p (d_dly[TRIG_STAGES].x),
		.t (trig_s[0]),
		.u_o (rx_u), .w_o (rx_w), .p_o (rx_p)
	);

	// about y: u = z, w = x
	rept_rot u_rot_y (
		.clk (clk), .en (en),
		.u (rx_w), .w (rx_p), .p (rx_u),
		.t (ty_dly[1]),
		.u_o (ry_u), .w_o (ry_w), .p_o (ry_p)
	);

	// about z: u = x, w = y
	rept_rot u_rot_z (
		.clk (clk), .en (en),
		.u (ry_w), .w (ry_p), .p (ry_u),
		.t (tz_dly[3]),
		.u_o (rz_u), .w_o (rz_w), .p_o (rz_p)
	);

	assign fin[0] = rz_u;
	assign fin[1] = rz_w;
	assign fin[2] = rz_p;

	// per-axis quotient lanes
	for (genvar l = 0; l < 3; l++) begin : g_term
		logic [CMP_WIDTH-1:0]  lim, magx;
		logic [AXIS_WIDTH-1:0] hi;
		logic                  over;
		assign mag[l] = fin[l][EXT_WIDTH-1] ? EXT_WIDTH'(-fin[l]) : EXT_WIDTH'(fin[l]);
		assign lim    = CMP_WIDTH'({axis_eff[l], 8'b0});
		assign magx   = CMP_WIDTH'(mag[l]);
		assign over   = magx >= lim;
		assign hi     = AXIS_WIDTH'(mag[l] >> 8);

		always_ff @(posedge clk) begin
			if (en) begin
				dq[l][0].rem <= over ? '0 : hi;
				dq[l][0].num <= {mag[l][7:0], {FRAC_BITS{1'b0}}};
				dq[l][0].quo <= '0;
				dq[l][0].sat <= over;
			end
		end

		for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_cell
			rept_div_cell u_cell (
				.clk  (clk),
				.en   (en),
				.axis (axis_eff[l]),
				.d    (dq[l][k]),
				.q    (dq[l][k+1])
			);
		end

		assign sq[l] = (2*QUO_WIDTH)'(dq[l][QUO_WIDTH].quo) * (2*QUO_WIDTH)'(dq[l][QUO_WIDTH].quo);

		always_ff @(posedge clk) begin
			if (en) begin
				term_s[l] <= sq[l][2*QUO_WIDTH-1:FRAC_BITS];
				tsat_s[l] <= dq[l][QUO_WIDTH].sat;
			end
		end
	end

	assign total = {2'b0, term_s[0]} + {2'b0, term_s[1]} + {2'b0, term_s[2]};

	always_ff @(posedge clk) begin
		if (en) begin
			res_s.sat   <= tsat_s[0] || tsat_s[1] || tsat_s[2] || (total[VALUE_WIDTH+1:VALUE_WIDTH] != 2'b0);
			res_s.value <= (tsat_s[0] || tsat_s[1] || tsat_s[2] ||
				(total[VALUE_WIDTH+1:VALUE_WIDTH] != 2'b0)) ? '1 : total[VALUE_WIDTH-1:0];
		end
	end

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			out_v_q  <= skid_v_q || (en && v_q[N_STAGES-1]);
			skid_v_q <= 1'b0;
		end else if (en && v_q[N_STAGES-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready) begin
			out_q <= skid_v_q ? skid_q : res_s;
		end else if (en && v_q[N_STAGES-1]) begin
			skid_q <= res_s;
		end
	end

	assign result.valid           = out_v_q;
	assign result.ellipsoid_value = out_q.value;
	assign result.saturated       = out_q.sat;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without output entry");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !result.ready && en && v_q[N_STAGES-1]) |=> skid_v_q)
		else $error("stalled result not captured in skid entry");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !result.ready) |=> skid_v_q)
		else $error("skid entry dropped while output stalled");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.sat) |-> (out_q.value == '1))
		else $error("saturated result not clamped");
endmodule
`default_nettype wire

// ----- test/rotated_ellipsoid_point_test_core_test.sv -----
`timescale 1ns / 1ps
module rotated_ellipsoid_point_test_core_test;
	import rept_pkg::*;

	typedef struct {
		logic signed [31:0] px, py, pz, sx_, sy, sz;
		logic [15:0] ax, ay, az;
	} query_t;

	typedef struct {
		logic [31:0] value;
		logic        sat;
	} ellipsoid_t;

	localparam int LATENCY = 52;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	rept_query_if  query();
	rept_result_if result();
	rept_cfg_if    cfg();

	rotated_ellipsoid_point_test_core uut (
		.clk(clk), .arst_n(arst_n), .query(query), .result(result), .cfg(cfg)
	);

	longint axis_x, axis_y, axis_z, ctr_x, ctr_y, ctr_z;
	ellipsoid_t expected_q[$];
	int failures = 0;
	longint cycles = 0;
	bit calm = 1'b0;

	const longint unsigned ATAN[16] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D
	};

	task automatic trig(input logic [15:0] ang, output longint s, output longint c);
		logic [31:0] a;
		bit flip;
		longint x, y, z, xs, ys;
		a = {ang, 16'd0};
		flip = a[31] ^ a[30];
		if (flip) a = a + 32'h80000000;
		x = 652032874;
		y = 0;
		z = longint'($signed(a));
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(ATAN[i]);
			end else begin
				x += ys; y -= xs; z += longint'(ATAN[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint rmul(longint a, longint t);
		bit neg;
		longint unsigned ua, ut, mag;
		neg = (a < 0) != (t < 0);
		ua = (a < 0) ? -a : a;
		ut = (t < 0) ? -t : t;
		mag = (ua >> 30) * ut + (((ua & 64'h3FFFFFFF) * ut + (64'd1 << 29)) >> 30);
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint unsigned axis_term(longint v, longint unsigned axis,
			inout bit sat);
		longint unsigned mag, r;
		mag = (v < 0) ? -v : v;
		if (axis == 0) axis = 1;
		if (mag >= (axis << 8)) begin
			sat = 1'b1;
			return 0;
		end
		r = (mag << 16) / axis;
		return (r * r) >> 16;
	endfunction

	task automatic predict_ellipsoid(input query_t q, output ellipsoid_t e);
		longint x, y, z, s, c, t1, t2;
		longint unsigned sum;
		bit sat;
		sat = 1'b0;
		x = longint'(q.px) - longint'(q.sx_) - ctr_x;
		y = longint'(q.py) - longint'(q.sy) - ctr_y;
		z = longint'(q.pz) - longint'(q.sz) - ctr_z;
		trig(q.ax, s, c);
		t1 = rmul(y, c) - rmul(z, s);
		t2 = rmul(y, s) + rmul(z, c);
		y = t1; z = t2;
		trig(q.ay, s, c);
		t1 = rmul(x, c) + rmul(z, s);
		t2 = rmul(z, c) - rmul(x, s);
		x = t1; z = t2;
		trig(q.az, s, c);
		t1 = rmul(x, c) - rmul(y, s);
		t2 = rmul(y, c) + rmul(x, s);
		x = t1; y = t2;
		sum = axis_term(x, axis_x, sat);
		sum += axis_term(y, axis_y, sat);
		sum += axis_term(z, axis_z, sat);
		if (sat || sum > 64'hFFFFFFFF) begin
			sat = 1'b1;
			sum = 64'hFFFFFFFF;
		end
		e.value = sum[31:0];
		e.sat = sat;
	endtask

	initial begin
		query.valid = 1'b0;
		query.point_x = '0; query.point_y = '0; query.point_z = '0;
		query.ship_x = '0; query.ship_y = '0; query.ship_z = '0;
		query.angle_x = '0; query.angle_y = '0; query.angle_z = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("rotated_ellipsoid_point_test_core test failed");
			$finish;
		end
	end

	// result side: random stall, check each transfer
	always @(posedge clk) begin
		ellipsoid_t e;
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result value %h", result.ellipsoid_value);
				failures++;
			end else begin
				e = expected_q.pop_front();
				if (result.ellipsoid_value !== e.value) begin
					$error("ellipsoid_value expected %h actual %h", e.value,
						result.ellipsoid_value);
					failures++;
				end
				if (result.saturated !== e.sat) begin
					$error("saturated expected %b actual %b", e.sat, result.saturated);
					failures++;
				end
			end
		end
		result.ready <= calm || ($urandom_range(99) >= 6);
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SEMI_AXIS_X: axis_x = val & 32'h7FFFFFFF;
			REG_SEMI_AXIS_Y: axis_y = val & 32'h7FFFFFFF;
			REG_SEMI_AXIS_Z: axis_z = val & 32'h7FFFFFFF;
			REG_CENTRE_X:    ctr_x = longint'($signed(val));
			REG_CENTRE_Y:    ctr_y = longint'($signed(val));
			REG_CENTRE_Z:    ctr_z = longint'($signed(val));
			default: ;
		endcase
	endtask

	task automatic send_query(input query_t q);
		ellipsoid_t e;
		while (!calm && $urandom_range(99) < 6) begin
			query.valid <= 1'b0;
			@(posedge clk);
		end
		query.valid <= 1'b1;
		query.point_x <= q.px; query.point_y <= q.py; query.point_z <= q.pz;
		query.ship_x <= q.sx_; query.ship_y <= q.sy; query.ship_z <= q.sz;
		query.angle_x <= q.ax; query.angle_y <= q.ay; query.angle_z <= q.az;
		@(posedge clk);
		while (!query.ready) @(posedge clk);
		predict_ellipsoid(q, e);
		expected_q.push_back(e);
	endtask

	task automatic drain();
		query.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
			2: return 32'($signed($urandom_range(1024)) - 512);
			default: return 32'($signed($urandom_range(400 * 65536)) - 200 * 65536);
		endcase
	endfunction

	function automatic query_t rnd_query();
		query_t q;
		q.px = rnd_coord(); q.py = rnd_coord(); q.pz = rnd_coord();
		if ($urandom_range(1)) begin
			q.sx_ = rnd_coord(); q.sy = rnd_coord(); q.sz = rnd_coord();
		end else begin
			q.sx_ = '0; q.sy = '0; q.sz = '0;
		end
		q.ax = $urandom; q.ay = $urandom; q.az = $urandom;
		return q;
	endfunction

	function automatic query_t mk(logic [31:0] px, py, pz, sx, sy, sz,
			logic [15:0] ax, ay, az);
		query_t q;
		q.px = px; q.py = py; q.pz = pz; q.sx_ = sx; q.sy = sy; q.sz = sz;
		q.ax = ax; q.ay = ay; q.az = az;
		return q;
	endfunction

	task automatic test_directed();
		send_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(mk(32'h8000, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(mk(32'h10000, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(mk(0, 32'h8000, 32'h4000, 0, 0, 0, 16'h4000, 16'h8000, 16'hC000));
		send_query(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_query(mk(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0001, 16'h3FFF, 16'h8001));
		send_query(mk(32'h00FF0000, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(mk(32'h01000000, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(mk(32'h00B00000, 32'h00B00000, 32'h00B00000, 0, 0, 0, 0, 0, 0));
		send_query(mk(32'h30000, 32'h20000, 32'h10000, 32'h10000, 32'h10000,
			32'h10000, 16'h2000, 16'h6000, 16'hA000));
		send_query(mk(32'hFFFFFFFF, 1, 32'hFFFF0000, 0, 0, 0, 16'h4000, 16'h4000,
			16'h4000));
		drain();
	endtask

	task automatic test_config_extremes();
		write_reg(REG_SEMI_AXIS_X, 32'h7FFFFFFF);
		write_reg(REG_SEMI_AXIS_Y, 32'h00000001);
		write_reg(REG_SEMI_AXIS_Z, 32'h80000000);
		write_reg(REG_CENTRE_X, 32'h80000000);
		write_reg(REG_CENTRE_Y, 32'h7FFFFFFF);
		write_reg(REG_CENTRE_Z, 32'hFFFF0000);
		repeat (40) send_query(rnd_query());
		send_query(mk(0, 32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 0, 0));
		drain();
		cfg.index <= CFG_IDX_NONE;
		cfg.data <= '1;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
		write_reg(REG_SEMI_AXIS_X, 32'h00020000);
		write_reg(REG_SEMI_AXIS_Y, 32'h00030000);
		write_reg(REG_SEMI_AXIS_Z, 32'h00008000);
		write_reg(REG_CENTRE_X, 32'h00010000);
		write_reg(REG_CENTRE_Y, 32'hFFFE0000);
		write_reg(REG_CENTRE_Z, 32'h00000000);
		repeat (40) send_query(rnd_query());
		drain();
	endtask

	task automatic test_random();
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_SEMI_AXIS_X, $urandom_range(1, 32'h00400000));
			write_reg(REG_SEMI_AXIS_Y, $urandom_range(1, 32'h00400000));
			write_reg(REG_SEMI_AXIS_Z, $urandom);
			write_reg(REG_CENTRE_X, rnd_coord());
			write_reg(REG_CENTRE_Y, rnd_coord());
			write_reg(REG_CENTRE_Z, rnd_coord());
			calm = (p == 2);
			repeat (110) send_query(rnd_query());
			drain();
		end
		calm = 1'b0;
	endtask

	task automatic test_wait_for_results();
		repeat (20) send_query(rnd_query());
		query.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) send_query(rnd_query());
		drain();
	endtask

	initial begin
		axis_x = 65536; axis_y = 65536; axis_z = 65536;
		ctr_x = 0; ctr_y = 0; ctr_z = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random();
		test_wait_for_results();
		if (failures == 0 && expected_q.size() == 0)
			$display("rotated_ellipsoid_point_test_core test passed");
		else
			$display("rotated_ellipsoid_point_test_core test failed");
		$finish;
	end
endmodule

// ----- sim.f -----
design/rept_pkg.sv
design/rept_intf.sv
design/rept_cordic_cell.sv
design/rept_div_cell.sv
design/rept_rot.sv
design/rotated_ellipsoid_point_test_core.sv
test/rotated_ellipsoid_point_test_core_test.sv
